[rtl/core/crtb_pkg.sv]
package crtb_pkg;

  localparam int unsigned BUFFER_BYTES = 8192;
  localparam int unsigned ADDR_W       = $clog2(BUFFER_BYTES);
  localparam int unsigned CHUNK_CAP    = 1024;

  localparam logic [31:0] BUF_SIZE_W  = 32'(BUFFER_BYTES);
  localparam logic [10:0] CHUNK_CAP_W = 11'(CHUNK_CAP);

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_SEEK  = 2'd2,
    MODE_READ  = 2'd3
  } crtb_mode_e;

  localparam logic [1:0] KIND_SEEK = 2'd0;
  localparam logic [1:0] KIND_CHAR = 2'd1;
  localparam logic [1:0] KIND_DROP = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LTR_N  = 8'h6E;
  localparam logic [7:0] CH_LTR_R  = 8'h72;
  localparam logic [7:0] CH_LTR_T  = 8'h74;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_char;
    logic [31:0] next_cursor;
    logic [10:0] avail_count;
    logic        last;
  } result_t;

endpackage

[rtl/core/crtb_if.sv]
interface crtb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  data_byte;
  logic [31:0] cursor_in;

  modport source (output valid, output mode, output data_byte, output cursor_in,
                  input ready);
  modport sink (input valid, input mode, input data_byte, input cursor_in,
                output ready);
endinterface

interface crtb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_char;
  logic [31:0] next_cursor;
  logic [10:0] avail_count;
  logic        last;

  modport source (output valid, output kind, output out_char, output next_cursor,
                  output avail_count, output last, input ready);
  modport sink (input valid, input kind, input out_char, input next_cursor,
                input avail_count, input last, output ready);
endinterface

[rtl/core/crtb_store.sv]
module crtb_store (
  input  logic                 clk_i,
  input  crtb_pkg::mem_req_t   req_i,
  output logic [7:0]           rd_data_o
);

  logic [7:0] mem [crtb_pkg::BUFFER_BYTES];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/core/crtb_ctrl.sv]
module crtb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  crtb_in_if.sink              in_i,
  crtb_out_if.source           out_o,
  input  logic                 cfg_we_i,
  input  logic [10:0]          cfg_data_i,
  output crtb_pkg::mem_req_t   mem_req_o,
  input  logic [7:0]           rd_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEEK_MAX,
    ST_SEEK_CAP,
    ST_RD_WAIT,
    ST_RD_ESC
  } state_e;

  state_e               state_q, state_d;
  logic [31:0]          total_q, total_d;
  logic [31:0]          pos_q, pos_d;
  logic [10:0]          rem_q, rem_d;
  logic [10:0]          cap_q, cap_d;
  logic [31:0]          cur_q, cur_d;
  logic [31:0]          old_q, old_d;
  logic [7:0]           esc_q, esc_d;
  logic                 out_valid_q, out_valid_d;
  crtb_pkg::result_t    out_q, out_d;

  logic                 slot_free;
  logic                 in_ready;
  logic                 accept;
  logic [31:0]          diff;
  logic [31:0]          pos_nx;
  logic [10:0]          rem_nx;
  logic [7:0]           esc;

  function automatic logic [7:0] escape_of(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      crtb_pkg::CH_QUOTE:  r = crtb_pkg::CH_QUOTE;
      crtb_pkg::CH_BSLASH: r = crtb_pkg::CH_BSLASH;
      crtb_pkg::CH_NL:     r = crtb_pkg::CH_LTR_N;
      crtb_pkg::CH_CR:     r = crtb_pkg::CH_LTR_R;
      crtb_pkg::CH_TAB:    r = crtb_pkg::CH_LTR_T;
      default:             r = 8'h00;
    endcase
    return r;
  endfunction

  assign slot_free = !out_valid_q || out_o.ready;
  assign in_ready  = (state_q == ST_IDLE) && slot_free;
  assign accept    = in_i.valid && in_ready;
  assign diff      = total_q - cur_q;
  assign pos_nx    = pos_q + 32'd1;
  assign rem_nx    = rem_q - 11'd1;
  assign esc       = escape_of(rd_data_i);

  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    pos_d       = pos_q;
    rem_d       = rem_q;
    cap_d       = cap_q;
    cur_d       = cur_q;
    old_d       = old_q;
    esc_d       = esc_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;
    mem_req_o   = '0;
    mem_req_o.waddr = total_q[crtb_pkg::ADDR_W-1:0];
    mem_req_o.wdata = in_i.data_byte;
    mem_req_o.raddr = pos_q[crtb_pkg::ADDR_W-1:0];

    if (cfg_we_i) begin
      cap_d = (cfg_data_i > crtb_pkg::CHUNK_CAP_W) ? crtb_pkg::CHUNK_CAP_W : cfg_data_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_i.mode)
            crtb_pkg::MODE_WRITE: begin
              mem_req_o.we = 1'b1;
              total_d      = total_q + 32'd1;
            end
            crtb_pkg::MODE_CLEAR: begin
              total_d = '0;
            end
            crtb_pkg::MODE_SEEK: begin
              cur_d   = (in_i.cursor_in > total_q) ? 32'd0 : in_i.cursor_in;
              old_d   = (total_q > crtb_pkg::BUF_SIZE_W) ?
                        (total_q - crtb_pkg::BUF_SIZE_W) : 32'd0;
              state_d = ST_SEEK_MAX;
            end
            default: begin
              if (rem_q == '0) begin
                out_valid_d = 1'b1;
                out_d       = '{crtb_pkg::KIND_NONE, 8'h00, pos_q, 11'd0, 1'b1};
              end else begin
                mem_req_o.re = 1'b1;
                state_d      = ST_RD_WAIT;
              end
            end
          endcase
        end
      end
      ST_SEEK_MAX: begin
        if (cur_q < old_q) begin
          cur_d = old_q;
        end
        state_d = ST_SEEK_CAP;
      end
      ST_SEEK_CAP: begin
        // diff never exceeds the buffer size here, so the low bits suffice below cap
        if (diff > {21'd0, cap_q}) begin
          rem_d = cap_q;
        end else begin
          rem_d = diff[10:0];
        end
        pos_d       = cur_q;
        out_valid_d = 1'b1;
        out_d       = '{crtb_pkg::KIND_SEEK, 8'h00, cur_q, rem_d, 1'b1};
        state_d     = ST_IDLE;
      end
      ST_RD_WAIT: begin
        pos_d       = pos_nx;
        rem_d       = rem_nx;
        out_valid_d = 1'b1;
        if (esc != 8'h00) begin
          esc_d   = esc;
          out_d   = '{crtb_pkg::KIND_CHAR, crtb_pkg::CH_BSLASH, pos_nx, rem_nx, 1'b0};
          state_d = ST_RD_ESC;
        end else if (rd_data_i >= crtb_pkg::CH_SPACE) begin
          out_d   = '{crtb_pkg::KIND_CHAR, rd_data_i, pos_nx, rem_nx, 1'b1};
          state_d = ST_IDLE;
        end else begin
          out_d   = '{crtb_pkg::KIND_DROP, 8'h00, pos_nx, rem_nx, 1'b1};
          state_d = ST_IDLE;
        end
      end
      ST_RD_ESC: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = '{crtb_pkg::KIND_CHAR, esc_q, pos_q, rem_q, 1'b1};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      total_q     <= '0;
      pos_q       <= '0;
      rem_q       <= '0;
      cap_q       <= crtb_pkg::CHUNK_CAP_W;
      cur_q       <= '0;
      old_q       <= '0;
      esc_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      pos_q       <= pos_d;
      rem_q       <= rem_d;
      cap_q       <= cap_d;
      cur_q       <= cur_d;
      old_q       <= old_d;
      esc_q       <= esc_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_q.kind;
  assign out_o.out_char    = out_q.out_char;
  assign out_o.next_cursor = out_q.next_cursor;
  assign out_o.avail_count = out_q.avail_count;
  assign out_o.last        = out_q.last;

endmodule

[rtl/core/cursor_ring_trace_buffer.sv]
// channel   dir  handshake      payload
// in_i      in   valid/ready    mode, data_byte, cursor_in
// out_o     out  valid/ready    kind, out_char, next_cursor, avail_count, last
// cfg       in   cfg_we_i       cfg_data_i = chunk_limit
//
// Write and clear are done when accepted; seek steps through clamp, raise and
// cap in the control FSM; read waits on the store's registered read port, with
// a further state for the second character of an escaped pair.
// The output register holds one result; a new request is taken only once
// the output register is empty or being drained.
// Reset clears counters and session; the byte store is not cleared.
module cursor_ring_trace_buffer (
  input  logic        clk_i,
  input  logic        rst_ni,
  crtb_in_if.sink     in_i,
  crtb_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_data_i
);

  crtb_pkg::mem_req_t mem_req;
  logic [7:0]         rd_data;

  crtb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .mem_req_o  (mem_req),
    .rd_data_i  (rd_data)
  );

  crtb_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

endmodule

[rtl/core/crtb_checker.sv]
module crtb_assert (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  kind_i,
  input logic [7:0]  out_char_i,
  input logic [31:0] next_cursor_i,
  input logic [10:0] avail_count_i,
  input logic        last_i
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) &&
      $stable(out_char_i) && $stable(next_cursor_i) && $stable(avail_count_i) &&
      $stable(last_i))
    else $error("stalled result changed");

  // no new request while a result is stuck
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("request taken while output blocked");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == crtb_pkg::KIND_NONE) |->
      avail_count_i == 11'd0 && out_char_i == 8'h00 && last_i)
    else $error("bad empty-read reply");

  // only the escape prefix is a non-final result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_i |->
      kind_i == crtb_pkg::KIND_CHAR && out_char_i == crtb_pkg::CH_BSLASH)
    else $error("non-final result is not an escape prefix");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == crtb_pkg::KIND_SEEK) |->
      avail_count_i <= crtb_pkg::CHUNK_CAP_W && last_i)
    else $error("seek reply over chunk cap");

endmodule

bind cursor_ring_trace_buffer crtb_assert u_crtb_assert (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .kind_i        (out_o.kind),
  .out_char_i    (out_o.out_char),
  .next_cursor_i (out_o.next_cursor),
  .avail_count_i (out_o.avail_count),
  .last_i        (out_o.last)
);

[test/crtb_checker.sv]
module crtb_checker
  import crtb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  crtb_in_if          in_w,
  crtb_out_if         out_w,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the trace buffer
  logic [7:0]  trace_mem [BUFFER_BYTES];
  logic [31:0] total_q;
  logic [31:0] read_pos_q;
  logic [10:0] read_left_q;
  logic [10:0] chunk_q;

  result_t expected_q [$];
  result_t exp_r;

  function automatic void push_result(input logic [1:0] kind, input logic [7:0] ch,
                                      input logic [31:0] cur, input logic [10:0] avail,
                                      input logic last);
    result_t r;
    r.kind        = kind;
    r.out_char    = ch;
    r.next_cursor = cur;
    r.avail_count = avail;
    r.last        = last;
    expected_q.push_back(r);
  endfunction

  task automatic predict_request(input crtb_mode_e m, input logic [7:0] b,
                                 input logic [31:0] cur);
    logic [31:0] start;
    logic [31:0] oldest;
    logic [31:0] avail;
    logic [10:0] cap;
    logic [7:0]  c;
    logic [7:0]  esc;
    case (m)
      MODE_WRITE: begin
        trace_mem[int'(total_q % BUF_SIZE_W)] = b;
        total_q = total_q + 32'd1;
      end
      MODE_CLEAR: begin
        total_q = '0;
      end
      MODE_SEEK: begin
        start  = (cur > total_q) ? 32'd0 : cur;
        oldest = (total_q > BUF_SIZE_W) ? total_q - BUF_SIZE_W : 32'd0;
        if (start < oldest) start = oldest;
        avail = total_q - start;
        cap   = (chunk_q > CHUNK_CAP_W) ? CHUNK_CAP_W : chunk_q;
        if (avail > 32'(cap)) avail = 32'(cap);
        read_pos_q  = start;
        read_left_q = avail[10:0];
        push_result(KIND_SEEK, 8'h00, start, avail[10:0], 1'b1);
      end
      default: begin
        if (read_left_q == '0) begin
          push_result(KIND_NONE, 8'h00, read_pos_q, 11'd0, 1'b1);
        end else begin
          c = trace_mem[int'(read_pos_q % BUF_SIZE_W)];
          read_pos_q  = read_pos_q + 32'd1;
          read_left_q = read_left_q - 11'd1;
          case (c)
            CH_QUOTE:  esc = CH_QUOTE;
            CH_BSLASH: esc = CH_BSLASH;
            CH_NL:     esc = CH_LTR_N;
            CH_CR:     esc = CH_LTR_R;
            CH_TAB:    esc = CH_LTR_T;
            default:   esc = 8'h00;
          endcase
          if (esc != 8'h00) begin
            push_result(KIND_CHAR, CH_BSLASH, read_pos_q, read_left_q, 1'b0);
            push_result(KIND_CHAR, esc, read_pos_q, read_left_q, 1'b1);
          end else if (c >= CH_SPACE) begin
            push_result(KIND_CHAR, c, read_pos_q, read_left_q, 1'b1);
          end else begin
            push_result(KIND_DROP, 8'h00, read_pos_q, read_left_q, 1'b1);
          end
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q      = '0;
      read_pos_q   = '0;
      read_left_q  = '0;
      chunk_q      = CHUNK_CAP_W;
      expected_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      if (cfg_we_i) chunk_q = cfg_data_i;
      // results leave before this edge's request adds new ones
      if (out_w.valid === 1'b1 && out_w.ready === 1'b1) begin
        if (expected_q.size() == 0) begin
          $error("result with no request pending: kind %0d char %0h", out_w.kind,
                 out_w.out_char);
          fail_count_o++;
        end else begin
          exp_r = expected_q.pop_front();
          checked_o++;
          if (out_w.kind !== exp_r.kind) begin
            $error("kind: expected %0d, got %0d", exp_r.kind, out_w.kind);
            fail_count_o++;
          end
          if (out_w.out_char !== exp_r.out_char) begin
            $error("out_char: expected %0h, got %0h", exp_r.out_char, out_w.out_char);
            fail_count_o++;
          end
          if (out_w.next_cursor !== exp_r.next_cursor) begin
            $error("next_cursor: expected %0d, got %0d", exp_r.next_cursor,
                   out_w.next_cursor);
            fail_count_o++;
          end
          if (out_w.avail_count !== exp_r.avail_count) begin
            $error("avail_count: expected %0d, got %0d", exp_r.avail_count,
                   out_w.avail_count);
            fail_count_o++;
          end
          if (out_w.last !== exp_r.last) begin
            $error("last: expected %0d, got %0d", exp_r.last, out_w.last);
            fail_count_o++;
          end
        end
      end
      if (in_w.valid === 1'b1 && in_w.ready === 1'b1) begin
        predict_request(crtb_mode_e'(in_w.mode), in_w.data_byte, in_w.cursor_in);
      end
      pending_o = expected_q.size();
    end
  end

endmodule

[test/tb_top.sv]
module tb_top;
  import crtb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [10:0] cfg_data_i = '0;

  crtb_in_if  in_if ();
  crtb_out_if out_if ();

  int          fail_count;
  int          pending;
  int          checked;
  int unsigned cycle_count = 0;
  int unsigned sent = 0;
  int unsigned settings = 0;
  bit          idle_on = 1'b1;
  logic [31:0] shadow_total = '0;
  logic [10:0] phase_limits [8];

  always #5 clk_i = ~clk_i;

  cursor_ring_trace_buffer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  crtb_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_w         (in_if),
    .out_w        (out_if),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("run exceeded %0d cycles, %0d results still pending", CYCLE_LIMIT, pending);
      $display("tb_top failed");
      $finish;
    end
  end

  // result side: random stall before each result while idle_on is set
  initial begin
    int unsigned gap;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = idle_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        out_if.ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_if.ready = 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
    end
  end

  function automatic logic [7:0] pick_byte();
    logic [7:0]  specials [5];
    int unsigned r;
    specials = '{CH_QUOTE, CH_BSLASH, CH_NL, CH_CR, CH_TAB};
    r = $urandom_range(0, 9);
    if (r < 3) return specials[$urandom_range(0, 4)];
    if (r == 3) return 8'($urandom_range(0, 31));
    return 8'($urandom);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(input crtb_mode_e m, input logic [7:0] b,
                              input logic [31:0] cur);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid     = 1'b1;
    in_if.mode      = m;
    in_if.data_byte = b;
    in_if.cursor_in = cur;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    @(negedge clk_i);
    if (m == MODE_WRITE) shadow_total = shadow_total + 32'd1;
    if (m == MODE_CLEAR) shadow_total = '0;
    sent++;
  endtask

  // register may only change with the block drained
  task automatic set_chunk_limit(input logic [10:0] v);
    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_data_i = v;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    cfg_data_i = 11'($urandom);
    settings++;
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned done;
    int unsigned r;
    int unsigned k;
    int unsigned len;
    logic [31:0] cur;
    done = 0;
    while (done < n) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        len = $urandom_range(1, 10);
        repeat (len) send_request(MODE_WRITE, pick_byte(), $urandom);
        done += len;
      end else if (r < 40) begin
        send_request(MODE_CLEAR, 8'($urandom), $urandom);
        done++;
      end else if (r < 80) begin
        k = $urandom_range(0, 9);
        if (k < 6) cur = shadow_total - $urandom_range(0, 20);
        else if (k == 6) cur = shadow_total + $urandom_range(1, 50);
        else if (k == 7) cur = $urandom;
        else if (k == 8) cur = '0;
        else cur = shadow_total;
        send_request(MODE_SEEK, 8'($urandom), cur);
        len = $urandom_range(1, 14);
        repeat (len) send_request(MODE_READ, 8'($urandom), $urandom);
        done += len + 1;
      end else if (r < 90) begin
        send_request(MODE_READ, 8'($urandom), $urandom);
        done++;
      end else begin
        send_request(MODE_SEEK, 8'($urandom), $urandom);
        done++;
      end
    end
  endtask

  initial begin
    logic [7:0]  seed_bytes [10];
    logic [31:0] cur;
    in_if.valid     = 1'b0;
    in_if.mode      = MODE_WRITE;
    in_if.data_byte = '0;
    in_if.cursor_in = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty buffer: read with no session, seek past the total
    send_request(MODE_READ, 8'hFF, 32'hFFFF_FFFF);
    send_request(MODE_SEEK, 8'h00, 32'hFFFF_FFFF);
    seed_bytes = '{CH_QUOTE, CH_BSLASH, CH_NL, CH_CR, CH_TAB,
                   8'h00, 8'h1F, CH_SPACE, 8'hFF, 8'h41};
    foreach (seed_bytes[i]) send_request(MODE_WRITE, seed_bytes[i], 32'h0);
    send_request(MODE_SEEK, 8'hFF, 32'h0);
    // one read beyond the session runs dry
    repeat (11) send_request(MODE_READ, 8'h00, 32'h0);
    send_request(MODE_SEEK, 8'h00, 32'd3);
    // clear mid-session: reads keep popping the old bytes
    send_request(MODE_CLEAR, 8'h00, 32'h0);
    repeat (2) send_request(MODE_READ, 8'h00, 32'h0);

    phase_limits = '{11'd1, 11'd0, 11'd2047, 11'd1024, 11'd5,
                     11'($urandom_range(2, 1023)), 11'd3, 11'd16};
    foreach (phase_limits[p]) begin
      set_chunk_limit(phase_limits[p]);
      idle_on = (p % 3 != 1);
      run_random(60);
    end

    set_chunk_limit(CHUNK_CAP_W);
    idle_on = 1'b1;
    // writes while a session is open, then a seek below a ring boundary
    send_request(MODE_SEEK, 8'h00, 32'h0);
    repeat (3) send_request(MODE_WRITE, pick_byte(), $urandom);
    repeat (6) send_request(MODE_READ, 8'($urandom), $urandom);
    cur = (shadow_total / BUF_SIZE_W) * BUF_SIZE_W - 32'd3;
    send_request(MODE_SEEK, 8'($urandom), cur);
    repeat (8) send_request(MODE_READ, 8'($urandom), $urandom);

    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("Sent %0d requests over %0d chunk_limit settings plus reset default,",
             sent, settings);
    $display("%0d results compared, %0d mismatches", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
